// File: design/kmt_pkg.sv
package kmt_pkg;

    localparam int TIME_W  = 32;
    localparam int MAP_W   = 64;
    localparam int DELAY_W = 16;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [DELAY_W-1:0] BOUNCE_DELAY_RESET = 16'd20;
    localparam logic [COUNT_W-1:0] ROWS_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] COLS_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNCE_DELAY = 2'd0,
        CFG_ROWS_IN_USE  = 2'd1,
        CFG_COLS_IN_USE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRESS,
        ST_RELEASE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] stamp_ms;
        logic [MAP_W-1:0]  pressed_map;
    } t_scan;

    typedef struct packed {
        logic       event_is_release;
        logic [2:0] key_row;
        logic [2:0] key_col;
        logic       last_event;
    } t_event;

endpackage

// File: design/kmt_ram.sv
module kmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/key_matrix_press_release_tracker_top.sv
// Key matrix press/release tracker. Each accepted scan (timestamp plus key bitmap) is
// walked twice through the per-key last-seen time memory, one key per cycle: a press
// pass that reports newly down keys and stores the scan time, then, when the scan time
// is at least the bounce delay, a release pass that reports and clears keys unseen for
// longer than the delay. Events come out in row-major order, presses first, and the
// final event of a scan carries last_event. The single read port of the time memory
// sets the pace of the walk, and a stalled output holds the walk. The time memory
// needs no clearing pass after reset: a flag per key marks entries written since reset.
module key_matrix_press_release_tracker_top #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  kmt_pkg::t_scan                    i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output kmt_pkg::t_event                   o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [kmt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kmt_pkg::DELAY_W-1:0]       i_cfg_wdata
);

    localparam int DEPTH = MAX_ROWS * 8;
    localparam int KEY_W = $clog2(DEPTH);
    localparam int CNT_W = KEY_W + 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(DEPTH);

    kmt_pkg::t_state r_state, n_state;

    logic [kmt_pkg::DELAY_W-1:0] r_bounce_delay;
    logic [kmt_pkg::COUNT_W-1:0] r_rows, r_cols;

    logic [CNT_W-1:0]            r_cnt;
    logic                        r_dv;
    logic [KEY_W-1:0]            r_didx;
    kmt_pkg::t_scan              r_scan;
    logic [kmt_pkg::TIME_W-1:0]  r_limit;
    logic                        r_do_rel;
    logic [DEPTH-1:0]            r_valid;

    logic                        r_p_vld;
    kmt_pkg::t_event             r_p;
    logic                        r_o_vld;
    kmt_pkg::t_event             r_o;

    logic                        w_accept;
    logic                        w_o_busy;
    logic                        w_walk;
    logic                        w_adv;
    logic                        w_issue;
    logic                        w_proc;
    logic                        w_pass_done;
    logic                        w_flush_move;
    logic [kmt_pkg::COUNT_W-1:0] w_nr, w_nc;
    logic [2:0]                  w_row, w_col;
    logic                        w_active;
    logic                        w_down;
    logic [kmt_pkg::TIME_W-1:0]  w_ram_q;
    logic [kmt_pkg::TIME_W-1:0]  w_d;
    logic                        w_press_hit;
    logic                        w_rel_hit;
    logic                        w_hit;
    logic                        w_ram_we;
    kmt_pkg::t_event             w_event;

    kmt_ram #(
        .WIDTH(kmt_pkg::TIME_W),
        .DEPTH(DEPTH)
    ) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_didx),
        .i_wdata(r_scan.stamp_ms),
        .i_re   (w_issue),
        .i_raddr(r_cnt[KEY_W-1:0]),
        .o_rdata(w_ram_q)
    );

    always_comb begin
        w_nr = (r_rows > kmt_pkg::COUNT_W'(MAX_ROWS)) ? kmt_pkg::COUNT_W'(MAX_ROWS) : r_rows;
        w_nc = (r_cols > kmt_pkg::COUNT_W'(MAX_COLS)) ? kmt_pkg::COUNT_W'(MAX_COLS) : r_cols;
    end

    // control outputs of the state machine
    always_comb begin
        w_accept     = (r_state == kmt_pkg::ST_IDLE) && i_in_valid;
        w_o_busy     = r_o_vld && i_out_stall;
        w_walk       = (r_state == kmt_pkg::ST_PRESS) || (r_state == kmt_pkg::ST_RELEASE);
        w_adv        = w_walk && !(r_p_vld && w_o_busy);
        w_issue      = w_adv && (r_cnt != CNT_END);
        w_proc       = w_adv && r_dv;
        w_pass_done  = w_walk && (r_cnt == CNT_END) && !r_dv;
        w_flush_move = (r_state == kmt_pkg::ST_FLUSH) && r_p_vld && !w_o_busy;

        w_row    = 3'(r_didx >> 3);
        w_col    = r_didx[2:0];
        w_active = ({1'b0, w_row} < w_nr) && ({1'b0, w_col} < w_nc);
        w_down   = r_scan.pressed_map[6'(r_didx)];
        w_d      = r_valid[r_didx] ? w_ram_q : '0;

        w_press_hit = (r_state == kmt_pkg::ST_PRESS) && w_active && w_down
                      && (w_d == '0);
        w_rel_hit   = (r_state == kmt_pkg::ST_RELEASE) && w_active
                      && (w_d != '0) && (w_d < r_limit);
        w_hit       = w_proc && (w_press_hit || w_rel_hit);
        w_ram_we    = w_proc && (r_state == kmt_pkg::ST_PRESS) && w_active && w_down;

        w_event.event_is_release = (r_state == kmt_pkg::ST_RELEASE);
        w_event.key_row          = w_row;
        w_event.key_col          = w_col;
        w_event.last_event       = 1'b0;

        o_in_stall  = (r_state != kmt_pkg::ST_IDLE);
        o_out_valid = r_o_vld;
        o_out_data  = r_o;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kmt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = kmt_pkg::ST_PRESS;
                end
            end
            kmt_pkg::ST_PRESS: begin
                if (w_pass_done) begin
                    n_state = r_do_rel ? kmt_pkg::ST_RELEASE : kmt_pkg::ST_FLUSH;
                end
            end
            kmt_pkg::ST_RELEASE: begin
                if (w_pass_done) begin
                    n_state = kmt_pkg::ST_FLUSH;
                end
            end
            kmt_pkg::ST_FLUSH: begin
                if (!r_p_vld || !w_o_busy) begin
                    n_state = kmt_pkg::ST_IDLE;
                end
            end
            default: n_state = kmt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= kmt_pkg::ST_IDLE;
            r_bounce_delay <= kmt_pkg::BOUNCE_DELAY_RESET;
            r_rows         <= kmt_pkg::ROWS_RESET;
            r_cols         <= kmt_pkg::COLS_RESET;
            r_cnt          <= '0;
            r_dv           <= 1'b0;
            r_valid        <= '0;
            r_p_vld        <= 1'b0;
            r_o_vld        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    kmt_pkg::CFG_BOUNCE_DELAY: r_bounce_delay <= i_cfg_wdata;
                    kmt_pkg::CFG_ROWS_IN_USE:  r_rows <= i_cfg_wdata[kmt_pkg::COUNT_W-1:0];
                    kmt_pkg::CFG_COLS_IN_USE:  r_cols <= i_cfg_wdata[kmt_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept || (w_pass_done && r_state == kmt_pkg::ST_PRESS)) begin
                r_cnt <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (w_accept) begin
                r_dv <= 1'b0;
            end else if (w_adv) begin
                r_dv <= w_issue;
            end

            if (w_ram_we) begin
                r_valid[r_didx] <= 1'b1;
            end else if (w_proc && w_rel_hit) begin
                r_valid[r_didx] <= 1'b0;
            end

            if (w_hit) begin
                r_p_vld <= 1'b1;
            end else if (w_flush_move) begin
                r_p_vld <= 1'b0;
            end

            if ((w_hit && r_p_vld) || w_flush_move) begin
                r_o_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scan   <= i_in_data;
            r_limit  <= i_in_data.stamp_ms - kmt_pkg::TIME_W'(r_bounce_delay);
            r_do_rel <= (i_in_data.stamp_ms >= kmt_pkg::TIME_W'(r_bounce_delay));
        end
        if (w_issue) begin
            r_didx <= r_cnt[KEY_W-1:0];
        end
        if (w_hit) begin
            r_p <= w_event;
        end
        if (w_hit && r_p_vld) begin
            r_o <= r_p;
        end else if (w_flush_move) begin
            r_o <= '{event_is_release: r_p.event_is_release, key_row: r_p.key_row,
                     key_col: r_p.key_col, last_event: 1'b1};
        end
    end

endmodule

// File: verif/key_matrix_event_checker.sv
module key_matrix_event_checker #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  kmt_pkg::t_scan                i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  kmt_pkg::t_event               i_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [kmt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kmt_pkg::DELAY_W-1:0]   i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    logic [kmt_pkg::TIME_W-1:0]  key_seen_ms [64];
    logic [kmt_pkg::DELAY_W-1:0] bounce_ms;
    logic [kmt_pkg::COUNT_W-1:0] rows_cfg;
    logic [kmt_pkg::COUNT_W-1:0] cols_cfg;
    kmt_pkg::t_event             due_events [$];
    int                          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        if (fail_count < 20) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        fail_count++;
    endtask

    // presses in row-major order, then releases of keys unseen past the bounce delay
    function automatic void scan_events(input kmt_pkg::t_scan scan);
        int unsigned                nr;
        int unsigned                nc;
        int                         idx;
        logic [kmt_pkg::TIME_W-1:0] limit;
        kmt_pkg::t_event            ev;
        kmt_pkg::t_event            found [$];
        nr = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        nc = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                idx = r * 8 + c;
                if (scan.pressed_map[idx]) begin
                    if (key_seen_ms[idx] == '0 && found.size() < 64) begin
                        ev = '{event_is_release: 1'b0, key_row: 3'(r), key_col: 3'(c),
                               last_event: 1'b0};
                        found.push_back(ev);
                    end
                    key_seen_ms[idx] = scan.stamp_ms;
                end
            end
        end
        if (scan.stamp_ms >= bounce_ms) begin
            limit = scan.stamp_ms - bounce_ms;
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    idx = r * 8 + c;
                    if (key_seen_ms[idx] != '0 && key_seen_ms[idx] < limit) begin
                        if (found.size() < 64) begin
                            ev = '{event_is_release: 1'b1, key_row: 3'(r), key_col: 3'(c),
                                   last_event: 1'b0};
                            found.push_back(ev);
                        end
                        key_seen_ms[idx] = '0;
                    end
                end
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last_event = 1'b1;
        end
        foreach (found[i]) begin
            due_events.push_back(found[i]);
        end
    endfunction

    always @(posedge i_clk) begin
        kmt_pkg::t_event want;
        if (!i_rst_n) begin
            foreach (key_seen_ms[k]) begin
                key_seen_ms[k] = '0;
            end
            bounce_ms = kmt_pkg::BOUNCE_DELAY_RESET;
            rows_cfg  = kmt_pkg::ROWS_RESET;
            cols_cfg  = kmt_pkg::COLS_RESET;
            due_events.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected event %p", i_out_data));
                end else begin
                    want = due_events.pop_front();
                    if (i_out_data.event_is_release !== want.event_is_release) begin
                        report_mismatch($sformatf("event_is_release %b, want %b",
                            i_out_data.event_is_release, want.event_is_release));
                    end
                    if (i_out_data.key_row !== want.key_row) begin
                        report_mismatch($sformatf("key_row %0d, want %0d",
                            i_out_data.key_row, want.key_row));
                    end
                    if (i_out_data.key_col !== want.key_col) begin
                        report_mismatch($sformatf("key_col %0d, want %0d",
                            i_out_data.key_col, want.key_col));
                    end
                    if (i_out_data.last_event !== want.last_event) begin
                        report_mismatch($sformatf("last_event %b, want %b",
                            i_out_data.last_event, want.last_event));
                    end
                end
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    kmt_pkg::CFG_BOUNCE_DELAY: bounce_ms = i_cfg_wdata;
                    kmt_pkg::CFG_ROWS_IN_USE:  rows_cfg  = i_cfg_wdata[kmt_pkg::COUNT_W-1:0];
                    kmt_pkg::CFG_COLS_IN_USE:  cols_cfg  = i_cfg_wdata[kmt_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                scan_events(i_in_data);
            end
        end
        o_pending = due_events.size();
    end

endmodule

// File: verif/key_matrix_press_release_tracker_top_test.sv
module key_matrix_press_release_tracker_top_test;

    localparam int SETTLE_CYCLES  = 2 * 64 + 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [kmt_pkg::MAP_W-1:0] ALL_KEYS = '1;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    kmt_pkg::t_scan                in_data = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    kmt_pkg::t_event               out_data;
    logic                          cfg_wr_en = 1'b0;
    logic [kmt_pkg::CFG_IDX_W-1:0] cfg_index = kmt_pkg::CFG_BOUNCE_DELAY;
    logic [kmt_pkg::DELAY_W-1:0]   cfg_wdata = '0;
    int                            fail_count;
    int                            pending;

    logic                          idle_on = 1'b1;
    int                            hold_off_cycles = 0;
    int                            quiet_cycles = 0;
    logic [kmt_pkg::TIME_W-1:0]    now_ms;
    logic [kmt_pkg::MAP_W-1:0]     held_keys;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    key_matrix_press_release_tracker_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    key_matrix_event_checker event_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // event sink: random stall per transaction, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 4) : 0;
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_scan(input logic [kmt_pkg::TIME_W-1:0] t,
                             input logic [kmt_pkg::MAP_W-1:0] map);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{stamp_ms: t, pressed_map: map};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_area(input logic [kmt_pkg::DELAY_W-1:0] delay,
                              input logic [kmt_pkg::DELAY_W-1:0] rows,
                              input logic [kmt_pkg::DELAY_W-1:0] cols);
        cfg_wr_en <= 1'b1;
        cfg_index <= kmt_pkg::CFG_BOUNCE_DELAY;
        cfg_wdata <= delay;
        @(posedge clk);
        cfg_index <= kmt_pkg::CFG_ROWS_IN_USE;
        cfg_wdata <= rows;
        @(posedge clk);
        cfg_index <= kmt_pkg::CFG_COLS_IN_USE;
        cfg_wdata <= cols;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly keys held and let go a few at a time, some noise scans and time jumps
    task automatic typing_burst(input int count, input logic [kmt_pkg::TIME_W-1:0] base_ms,
                                input logic [kmt_pkg::DELAY_W-1:0] delay);
        logic [kmt_pkg::MAP_W-1:0] map;
        int                        sel;
        int                        k;
        now_ms    = base_ms;
        held_keys = {$urandom(), $urandom()} & {$urandom(), $urandom()}
                    & {$urandom(), $urandom()};
        repeat (count) begin
            sel = $urandom_range(0, 15);
            if (sel == 0) begin
                map = {$urandom(), $urandom()};
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    k = $urandom_range(0, 63);
                    held_keys[k] = ~held_keys[k];
                end
                if (sel == 1) begin
                    held_keys = '0;
                end
                map = held_keys;
            end
            if (sel == 2) begin
                now_ms += $urandom_range(0, 4 * delay + 64);
            end else begin
                now_ms += $urandom_range(0, delay / 8 + 2);
            end
            send_scan(now_ms, map);
        end
    endtask

    initial begin
        logic [kmt_pkg::DELAY_W-1:0] rand_delay;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: delay 20, full 8x8 matrix
        send_scan(32'd0, ALL_KEYS);
        send_scan(32'd0, ALL_KEYS);
        send_scan(32'd5, 64'h1);
        send_scan(32'd10, ALL_KEYS);
        send_scan(32'd40, '0);
        send_scan(32'd41, '0);
        send_scan(32'hFFFF_FFF0, 64'h8000_0000_0000_0001);
        send_scan(32'hFFFF_FFFF, '0);
        send_scan(32'd3, 64'h2);
        send_scan(32'd30, '0);

        drain();
        write_area(16'd0, 16'hFFF3, 16'd5);
        send_scan(32'd100, ALL_KEYS);
        send_scan(32'd100, ALL_KEYS);
        send_scan(32'd101, '0);

        drain();
        write_area(16'hFFFF, 16'd0, 16'd8);
        send_scan(32'd200, ALL_KEYS);

        drain();
        write_area(16'hFFFF, 16'h000F, 16'h0009);
        send_scan(32'd70000, 64'h00FF_0000_0000_FF00);
        send_scan(32'd135536, '0);
        send_scan(32'd65534, ALL_KEYS);
        send_scan(32'd65535, '0);

        drain();
        write_area(16'd20, 16'd8, 16'd8);
        typing_burst(50, $urandom(), 16'd20);

        drain();
        idle_on = 1'b0;
        write_area(16'd5, 16'd4, 16'd6);
        typing_burst(40, 32'hFFFF_FF80, 16'd5);

        drain();
        idle_on = 1'b1;
        rand_delay = kmt_pkg::DELAY_W'($urandom_range(0, 40));
        write_area(rand_delay, kmt_pkg::DELAY_W'($urandom()), kmt_pkg::DELAY_W'($urandom()));
        hold_off_cycles = 400;
        typing_burst(50, $urandom(), rand_delay);

        drain();
        write_area(16'd12, 16'd8, 16'd8);
        typing_burst(60, $urandom(), 16'd12);

        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
